/* hw/rtl/lbphm_pkg.sv */
// Package for the peak-hold LED bar meter: widths, reset values, register
// indexes and command codes for the top level; the segment decoder uses its widths.
// No dependencies.
package lbphm_pkg;

  // Default geometry and fixed point format
  localparam int MAX_SEGMENTS    = 64;
  localparam int LEVEL_FRAC_BITS = 15;
  localparam int MIN_SEGMENTS    = 4;

  // Fixed field widths
  localparam int LEVEL_W    = 16;
  localparam int LEVEL_IN_W = 17;
  localparam int SEG_CNT_W  = 7;
  localparam int CMD_W      = 2;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Register reset values
  localparam logic [SEG_CNT_W-1:0] RST_SEGMENT_COUNT = 7'd16;
  localparam logic [LEVEL_W-1:0]   RST_YELLOW_START  = 16'd22938;
  localparam logic [LEVEL_W-1:0]   RST_RED_START     = 16'd29491;
  localparam logic [LEVEL_W-1:0]   RST_FALL_STEP     = 16'd16;
  localparam logic [LEVEL_W-1:0]   RST_HOLD_TICKS    = 16'd90;
  localparam logic                 RST_RMS_ENABLE    = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEGMENT_COUNT = 3'd0,
    REG_YELLOW_START  = 3'd1,
    REG_RED_START     = 3'd2,
    REG_FALL_STEP     = 3'd3,
    REG_HOLD_TICKS    = 3'd4,
    REG_RMS_ENABLE    = 3'd5
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PEAK = 2'd0,
    CMD_RMS  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

endpackage

/* hw/rtl/led_bar_peak_hold_meter_unit.sv */
// Top level of the peak-hold LED bar meter: configuration registers, level
// state, count stage and output register. Depends on lbphm_pkg and
// lbphm_seg_decode.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   in_     | sink      | in_valid / in_stall   | in_command, in_level_in
//   out_    | source    | out_valid / out_stall | out_*_lit masks, marker, peak, held
//   cfg     | APB slave | psel/penable/pready   | paddr, pwdata, prdata
//
// One request per cycle is accepted while in_stall is low. A result reaches the
// output register through the level state update, the level-to-count multiply
// and the segment decode, each of which takes one register stage.
// Reset (rst_n low, synchronous) restores register defaults and clears all levels.
// A stalled output holds its result; the two inner stages keep filling, and
// in_stall rises only once the stage behind the level state is also full.
module led_bar_peak_hold_meter_unit #(
  parameter int MaxSegments   = lbphm_pkg::MAX_SEGMENTS,
  parameter int LevelFracBits = lbphm_pkg::LEVEL_FRAC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // request channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [lbphm_pkg::CMD_W-1:0]             in_command,
  input  logic signed [lbphm_pkg::LEVEL_IN_W-1:0] in_level_in,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [MaxSegments-1:0]                  out_green_lit,
  output logic [MaxSegments-1:0]                  out_yellow_lit,
  output logic [MaxSegments-1:0]                  out_red_lit,
  output logic [MaxSegments-1:0]                  out_rms_lit,
  output logic [$clog2(MaxSegments)-1:0]          out_marker_segment,
  output logic [lbphm_pkg::LEVEL_W-1:0]           out_peak_out,
  output logic [lbphm_pkg::LEVEL_W-1:0]           out_held_out,
  // configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [lbphm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [lbphm_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [lbphm_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                    pready
);

  localparam int LW     = lbphm_pkg::LEVEL_W;
  localparam int CNT_W  = $clog2(MaxSegments+1);
  localparam int MRK_W  = $clog2(MaxSegments);
  localparam int THR_W  = LW + CNT_W;
  localparam int PROD_W = LW + CNT_W;
  localparam int DW     = lbphm_pkg::APB_DATA_W;

  localparam logic [LW-1:0] LEVEL_ONE  = LW'(1) << LevelFracBits;
  localparam logic [LW-1:0] LEVEL_HALF = LEVEL_ONE >> 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lbphm_pkg::SEG_CNT_W-1:0] seg_cnt_r;
  logic [LW-1:0]                   yel_start_r;
  logic [LW-1:0]                   red_start_r;
  logic [LW-1:0]                   fall_step_r;
  logic [LW-1:0]                   hold_ticks_r;
  logic                            rms_en_r;

  lbphm_pkg::reg_idx_t reg_idx;
  logic                cfg_wr;

  assign reg_idx = lbphm_pkg::reg_idx_t'(paddr[lbphm_pkg::APB_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r    <= lbphm_pkg::RST_SEGMENT_COUNT;
      yel_start_r  <= lbphm_pkg::RST_YELLOW_START;
      red_start_r  <= lbphm_pkg::RST_RED_START;
      fall_step_r  <= lbphm_pkg::RST_FALL_STEP;
      hold_ticks_r <= lbphm_pkg::RST_HOLD_TICKS;
      rms_en_r     <= lbphm_pkg::RST_RMS_ENABLE;
    end else if (cfg_wr) begin
      case (reg_idx)
        lbphm_pkg::REG_SEGMENT_COUNT: seg_cnt_r    <= pwdata[lbphm_pkg::SEG_CNT_W-1:0];
        lbphm_pkg::REG_YELLOW_START:  yel_start_r  <= pwdata[LW-1:0];
        lbphm_pkg::REG_RED_START:     red_start_r  <= pwdata[LW-1:0];
        lbphm_pkg::REG_FALL_STEP:     fall_step_r  <= pwdata[LW-1:0];
        lbphm_pkg::REG_HOLD_TICKS:    hold_ticks_r <= pwdata[LW-1:0];
        lbphm_pkg::REG_RMS_ENABLE:    rms_en_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lbphm_pkg::REG_SEGMENT_COUNT: prdata = DW'(seg_cnt_r);
      lbphm_pkg::REG_YELLOW_START:  prdata = DW'(yel_start_r);
      lbphm_pkg::REG_RED_START:     prdata = DW'(red_start_r);
      lbphm_pkg::REG_FALL_STEP:     prdata = DW'(fall_step_r);
      lbphm_pkg::REG_HOLD_TICKS:    prdata = DW'(hold_ticks_r);
      lbphm_pkg::REG_RMS_ENABLE:    prdata = DW'(rms_en_r);
      default:                      prdata = '0;
    endcase
  end

  // Segment total, saturated to the supported range
  logic [CNT_W-1:0] seg_n;

  always_comb begin
    if (seg_cnt_r < lbphm_pkg::SEG_CNT_W'(lbphm_pkg::MIN_SEGMENTS)) begin
      seg_n = CNT_W'(lbphm_pkg::MIN_SEGMENTS);
    end else if (seg_cnt_r > lbphm_pkg::SEG_CNT_W'(MaxSegments)) begin
      seg_n = CNT_W'(MaxSegments);
    end else begin
      seg_n = seg_cnt_r[CNT_W-1:0];
    end
  end

  // Zone thresholds scaled by N, so a segment top (i+1)*ONE compares exactly.
  // Config must change only while idle (not enforced), so these settle before use.
  logic [THR_W-1:0] yel_thr_r;
  logic [THR_W-1:0] red_thr_r;

  always_ff @(posedge clk) begin
    yel_thr_r <= THR_W'(yel_start_r) * THR_W'(seg_n);
    red_thr_r <= THR_W'(red_start_r) * THR_W'(seg_n);
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: level state -> counts -> output register
  // ---------------------------------------------------------------------------
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic in_acc, s2_take, out_take;

  assign out_take = s2_v_r & (~out_v_r | ~out_stall);
  assign s2_take  = s1_v_r & (~s2_v_r | out_take);
  assign in_stall = s1_v_r & ~s2_take;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    s1_v_nxt  = in_acc | (s1_v_r & ~s2_take);
    s2_v_nxt  = s2_take | (s2_v_r & ~out_take);
    out_v_nxt = out_take | (out_v_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;

  // ---------------------------------------------------------------------------
  // Stage 1: level state update at request accept
  // ---------------------------------------------------------------------------
  logic [LW-1:0] peak_r, peak_nxt;
  logic [LW-1:0] rms_r, rms_nxt;
  logic [LW-1:0] held_r, held_nxt;
  logic [LW-1:0] hold_rem_r, hold_rem_nxt;

  logic [LW-1:0] lvl;
  logic [LW-1:0] peak_dec;
  logic [LW:0]   drop;
  logic [LW-1:0] held_dec;

  always_comb begin
    // Clamp the signed sample to 0..ONE
    if (in_level_in[lbphm_pkg::LEVEL_IN_W-1]) begin
      lvl = '0;
    end else if (in_level_in[LW-1:0] > LEVEL_ONE) begin
      lvl = LEVEL_ONE;
    end else begin
      lvl = in_level_in[LW-1:0];
    end

    peak_dec = (peak_r > fall_step_r) ? (peak_r - fall_step_r) : '0;
    drop     = {fall_step_r, 1'b0};
    held_dec = ({1'b0, held_r} > drop) ? LW'({1'b0, held_r} - drop) : '0;

    peak_nxt     = peak_r;
    rms_nxt      = rms_r;
    held_nxt     = held_r;
    hold_rem_nxt = hold_rem_r;

    if (in_acc) begin
      case (lbphm_pkg::cmd_t'(in_command))
        lbphm_pkg::CMD_PEAK: begin
          // A sample at or above the peak takes over and restarts the hold
          if (lvl >= peak_r) begin
            peak_nxt     = lvl;
            held_nxt     = lvl;
            hold_rem_nxt = hold_ticks_r;
          end
        end
        lbphm_pkg::CMD_RMS: begin
          rms_nxt = lvl;
        end
        lbphm_pkg::CMD_TICK: begin
          peak_nxt = peak_dec;
          if (hold_rem_r != '0) begin
            hold_rem_nxt = hold_rem_r - LW'(1);
          end else begin
            // Hold expired: fall twice as fast, but never under the peak
            held_nxt = (held_dec > peak_dec) ? held_dec : peak_dec;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r     <= '0;
      rms_r      <= '0;
      held_r     <= '0;
      hold_rem_r <= '0;
    end else begin
      peak_r     <= peak_nxt;
      rms_r      <= rms_nxt;
      held_r     <= held_nxt;
      hold_rem_r <= hold_rem_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: levels to segment counts, round half up
  // ---------------------------------------------------------------------------
  function automatic logic [CNT_W-1:0] level_count(input logic [LW-1:0] level,
                                                   input logic [CNT_W-1:0] n);
    logic [PROD_W-1:0] sum;
    logic [CNT_W:0]    c;
    sum = PROD_W'(level) * PROD_W'(n) + PROD_W'(LEVEL_HALF);
    c   = sum[LevelFracBits +: CNT_W+1];
    return (c > {1'b0, n}) ? n : c[CNT_W-1:0];
  endfunction

  logic [CNT_W-1:0] lit_peak_r, lit_rms_r;
  logic [MRK_W-1:0] marker_r;
  logic [LW-1:0]    s2_peak_r, s2_held_r;
  logic [CNT_W-1:0] held_cnt;
  logic [CNT_W-1:0] last_seg;
  logic [CNT_W-1:0] marker_full;

  always_comb begin
    held_cnt    = level_count(held_r, seg_n);
    last_seg    = seg_n - CNT_W'(1);
    marker_full = (held_cnt > last_seg) ? last_seg : held_cnt;
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      lit_peak_r <= level_count(peak_r, seg_n);
      lit_rms_r  <= level_count(rms_r, seg_n);
      marker_r   <= marker_full[MRK_W-1:0];
      s2_peak_r  <= peak_r;
      s2_held_r  <= held_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: segment decode into the output register
  // ---------------------------------------------------------------------------
  logic [MaxSegments-1:0] green_mask, yellow_mask, red_mask, rms_mask;

  lbphm_seg_decode #(
    .MaxSegments  (MaxSegments),
    .LevelFracBits(LevelFracBits)
  ) u_seg_decode (
    .lit_peak   (lit_peak_r),
    .lit_rms    (lit_rms_r),
    .rms_en     (rms_en_r),
    .yellow_thr (yel_thr_r),
    .red_thr    (red_thr_r),
    .green_mask (green_mask),
    .yellow_mask(yellow_mask),
    .red_mask   (red_mask),
    .rms_mask   (rms_mask)
  );

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_green_lit      <= green_mask;
      out_yellow_lit     <= yellow_mask;
      out_red_lit        <= red_mask;
      out_rms_lit        <= rms_mask;
      out_marker_segment <= marker_r;
      out_peak_out       <= s2_peak_r;
      out_held_out       <= s2_held_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_held_not_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
    held_r >= peak_r)
    else $error("held level dropped below peak level");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty state stage");

  a_count_within_n: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (lit_peak_r <= seg_n && lit_rms_r <= seg_n))
    else $error("segment count exceeds segment total");

  a_zones_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_green_lit & out_yellow_lit) == '0 &&
                 (out_green_lit & out_red_lit) == '0 &&
                 (out_yellow_lit & out_red_lit) == '0))
    else $error("segment lit in more than one color zone");

endmodule

/* hw/rtl/lbphm_seg_decode.sv */
// Segment decoder: turns lit counts and zone thresholds into color masks
// and the RMS overlay mask. Depends on lbphm_pkg.
module lbphm_seg_decode #(
  parameter int MaxSegments   = lbphm_pkg::MAX_SEGMENTS,
  parameter int LevelFracBits = lbphm_pkg::LEVEL_FRAC_BITS
) (
  input  logic [$clog2(MaxSegments+1)-1:0]                   lit_peak,
  input  logic [$clog2(MaxSegments+1)-1:0]                   lit_rms,
  input  logic                                               rms_en,
  input  logic [lbphm_pkg::LEVEL_W+$clog2(MaxSegments+1)-1:0] yellow_thr,
  input  logic [lbphm_pkg::LEVEL_W+$clog2(MaxSegments+1)-1:0] red_thr,
  output logic [MaxSegments-1:0]                             green_mask,
  output logic [MaxSegments-1:0]                             yellow_mask,
  output logic [MaxSegments-1:0]                             red_mask,
  output logic [MaxSegments-1:0]                             rms_mask
);

  localparam int CNT_W = $clog2(MaxSegments+1);
  localparam int THR_W = lbphm_pkg::LEVEL_W + CNT_W;

  // Each segment is judged by its top edge (i+1)/N against the scaled thresholds
  for (genvar i = 0; i < MaxSegments; i++) begin : g_seg
    logic [THR_W-1:0] top;
    logic             lit;
    logic             in_red;
    logic             in_yel;

    assign top    = THR_W'(i + 1) << LevelFracBits;
    assign lit    = CNT_W'(i) < lit_peak;
    assign in_red = top >= red_thr;
    assign in_yel = top >= yellow_thr;

    assign red_mask[i]    = lit & in_red;
    assign yellow_mask[i] = lit & ~in_red & in_yel;
    assign green_mask[i]  = lit & ~in_red & ~in_yel;
    assign rms_mask[i]    = rms_en & (CNT_W'(i) < lit_rms);
  end

endmodule
